FILE: src/sodq_pkg.sv
// shared types and constants for the size ordered dedup queue
// no dependencies
package sodq_pkg;

	localparam int QueueDepth = 16;
	localparam int IDX_W = $clog2(QueueDepth);
	localparam int CNT_W = $clog2(QueueDepth + 1);
	localparam int COUNT_W = 5;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_PICK = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_FLUSH = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_APPLY,
		S_FLUSH,
		S_FLUSH_END,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic apply;
		logic flush_step;
		logic flush_end;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_flush;
		logic flush_last;
		logic out_busy;
	} stat_t;

endpackage

FILE: src/sodq_ctrl.sv
// controller state machine of the size ordered dedup queue
// depends on sodq_pkg
module sodq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  sodq_pkg::stat_t st,
	output sodq_pkg::cmd_t  cmd
);
	import sodq_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_n = S_EVAL;
			end
			S_EVAL: begin
				state_n = st.is_flush ? S_FLUSH : S_APPLY;
			end
			S_APPLY: state_n = S_EMIT;
			S_FLUSH: begin
				if (st.flush_last) state_n = S_FLUSH_END;
			end
			S_FLUSH_END: state_n = S_EMIT;
			S_EMIT: begin
				if (!st.out_busy) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_EVAL: cmd.eval = 1'b1;
			S_APPLY: cmd.apply = 1'b1;
			S_FLUSH: cmd.flush_step = 1'b1;
			S_FLUSH_END: cmd.flush_end = 1'b1;
			S_EMIT: cmd.emit = !st.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: src/sodq_datapath.sv
// slot cells, compare logic, flush compaction and output register
// depends on sodq_pkg, driven by sodq_ctrl commands
module sodq_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  sodq_pkg::cmd_t  cmd,
	output sodq_pkg::stat_t st,
	input  logic [1:0]     in_mode,
	input  logic [31:0]    in_id,
	input  logic [31:0]    in_size,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_status,
	output logic [31:0]    out_id,
	output logic [31:0]    out_size,
	output logic [sodq_pkg::COUNT_W-1:0] out_count
);
	import sodq_pkg::*;

	logic [31:0] slot_id_q [QueueDepth];
	logic [31:0] slot_size_q [QueueDepth];
	logic [QueueDepth-1:0] send_q;
	logic [CNT_W-1:0] count_q;

	logic [31:0] id_n [QueueDepth];
	logic [31:0] size_n [QueueDepth];
	logic [QueueDepth-1:0] send_n;
	logic [CNT_W-1:0] count_n;

	logic [1:0] mode_q;
	logic [31:0] key_id_q, key_size_q;

	logic [QueueDepth-1:0] vld, hit, lt, waiting;
	logic [QueueDepth-1:0] b_c, a_c, po_c, pf_c;
	logic ins0, seen;

	logic [QueueDepth-1:0] b_s1, a_s1, po_s1, pick_s1;
	logic anyhit_s1, anypick_s1, full_s1;

	logic [IDX_W-1:0] r_q;
	logic [CNT_W-1:0] w_q;

	logic [1:0] res_status_q;
	logic [31:0] res_id_q, res_size_q;
	logic [1:0] res_status_n;
	logic [31:0] res_id_n, res_size_n, pid, psize;

	logic out_valid_q;
	logic [1:0] out_status_q;
	logic [31:0] out_id_q, out_size_q;
	logic [CNT_W-1:0] out_count_q;

	// per-slot compares and ripple chains
	always_comb begin
		for (int j = 0; j < QueueDepth; j++) begin
			vld[j] = CNT_W'(j) < count_q;
			hit[j] = vld[j] && slot_id_q[j] == key_id_q && slot_size_q[j] == key_size_q;
			lt[j] = vld[j] && slot_size_q[j] < key_size_q;
			waiting[j] = vld[j] && !send_q[j];
		end
		ins0 = (count_q == '0) || (slot_size_q[0] > key_size_q);
		b_c[0] = !ins0;
		a_c[0] = hit[0];
		po_c[0] = ins0;
		pf_c[0] = waiting[0];
		seen = waiting[0];
		for (int j = 1; j < QueueDepth; j++) begin
			b_c[j] = b_c[j-1] & lt[j];
			a_c[j] = a_c[j-1] | hit[j];
			po_c[j] = !b_c[j] & b_c[j-1];
			pf_c[j] = waiting[j] & !seen;
			seen = seen | waiting[j];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			key_id_q <= in_id;
			key_size_q <= in_size;
		end
		if (cmd.eval) begin
			b_s1 <= b_c;
			a_s1 <= a_c;
			po_s1 <= po_c;
			pick_s1 <= pf_c;
			anyhit_s1 <= a_c[QueueDepth-1];
			anypick_s1 <= seen;
			full_s1 <= count_q == CNT_W'(QueueDepth);
		end
	end

	// picked entry, one-hot select
	always_comb begin
		pid = '0;
		psize = '0;
		for (int j = 0; j < QueueDepth; j++) begin
			pid = pid | ({32{pick_s1[j]}} & slot_id_q[j]);
			psize = psize | ({32{pick_s1[j]}} & slot_size_q[j]);
		end
	end

	// next slot contents
	always_comb begin
		for (int j = 0; j < QueueDepth; j++) begin
			id_n[j] = slot_id_q[j];
			size_n[j] = slot_size_q[j];
		end
		send_n = send_q;
		count_n = count_q;
		res_status_n = ST_OK;
		res_id_n = '0;
		res_size_n = '0;
		if (cmd.apply) begin
			case (mode_q)
				MODE_INSERT: begin
					if (anyhit_s1) begin
						res_status_n = ST_DUP;
					end else if (full_s1) begin
						res_status_n = ST_FULL;
					end else begin
						if (po_s1[0]) begin
							id_n[0] = key_id_q;
							size_n[0] = key_size_q;
							send_n[0] = 1'b0;
						end
						for (int j = 1; j < QueueDepth; j++) begin
							if (po_s1[j]) begin
								id_n[j] = key_id_q;
								size_n[j] = key_size_q;
								send_n[j] = 1'b0;
							end else if (!b_s1[j]) begin
								id_n[j] = slot_id_q[j-1];
								size_n[j] = slot_size_q[j-1];
								send_n[j] = send_q[j-1];
							end
						end
						count_n = count_q + 1'b1;
					end
				end
				MODE_PICK: begin
					if (anypick_s1) begin
						send_n = send_q | pick_s1;
						res_id_n = pid;
						res_size_n = psize;
					end else begin
						res_status_n = ST_NONE;
					end
				end
				MODE_REMOVE: begin
					if (anyhit_s1) begin
						// slots from the match upward take their upper neighbor
						for (int j = 0; j < QueueDepth - 1; j++) begin
							if (a_s1[j]) begin
								id_n[j] = slot_id_q[j+1];
								size_n[j] = slot_size_q[j+1];
								send_n[j] = send_q[j+1];
							end
						end
						if (a_s1[QueueDepth-1]) send_n[QueueDepth-1] = 1'b0;
						count_n = count_q - 1'b1;
					end else begin
						res_status_n = ST_NONE;
					end
				end
				default: res_status_n = ST_OK;
			endcase
		end
		if (cmd.flush_step && (CNT_W'(r_q) < count_q) && send_q[r_q]) begin
			id_n[w_q[IDX_W-1:0]] = slot_id_q[r_q];
			size_n[w_q[IDX_W-1:0]] = slot_size_q[r_q];
			send_n[w_q[IDX_W-1:0]] = 1'b1;
		end
		if (cmd.flush_end) begin
			for (int j = 0; j < QueueDepth; j++) begin
				if (CNT_W'(j) >= w_q) send_n[j] = 1'b0;
			end
			count_n = w_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < QueueDepth; j++) begin
			slot_id_q[j] <= id_n[j];
			slot_size_q[j] <= size_n[j];
		end
		if (cmd.apply || cmd.flush_end) begin
			res_status_q <= res_status_n;
			res_id_q <= res_id_n;
			res_size_q <= res_size_n;
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_id_q <= res_id_q;
			out_size_q <= res_size_q;
			out_count_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_q <= '0;
			count_q <= '0;
			r_q <= '0;
			w_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			send_q <= send_n;
			count_q <= count_n;
			if (cmd.load) begin
				r_q <= '0;
				w_q <= '0;
			end else if (cmd.flush_step) begin
				r_q <= r_q + 1'b1;
				if ((CNT_W'(r_q) < count_q) && send_q[r_q]) w_q <= w_q + 1'b1;
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign st.is_flush = mode_q == MODE_FLUSH;
	assign st.flush_last = r_q == IDX_W'(QueueDepth - 1);
	assign st.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_id = out_id_q;
	assign out_size = out_size_q;
	assign out_count = COUNT_W'(out_count_q);

endmodule

FILE: src/size_ordered_dedup_queue_core.sv
// top level of the size ordered dedup queue
// depends on sodq_pkg, sodq_ctrl and sodq_datapath
//
// channel   dir  handshake           contents
// s_*       in   s_tvalid/s_tready   tuser mode, tdata file_id, file_size
// m_*       out  m_tvalid/m_tready   tuser status, tdata out_id, out_size, count
//
// insert, pick and remove pass these steps from accept to result beat:
// accept, compare over all slot cells, update of the cells, output load
// flush walks the slots one per cycle
// a new beat is taken while the previous result still waits on m_tready
// reset clears the sending marks, the entry count and the output valid
module size_ordered_dedup_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // file_id[31:0], file_size[63:32]
	input  logic [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // out_id[31:0], out_size[63:32], count[68:64], zero
	output logic [1:0]  m_tuser   // status[1:0]
);
	import sodq_pkg::*;

	cmd_t cmd;
	stat_t st;
	logic [31:0] out_id, out_size;
	logic [COUNT_W-1:0] out_count;

	// sequencer: one beat at a time
	sodq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	// slot cells and result register
	sodq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_mode   (s_tuser),
		.in_id     (s_tdata[31:0]),
		.in_size   (s_tdata[63:32]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_status(m_tuser),
		.out_id    (out_id),
		.out_size  (out_size),
		.out_count (out_count)
	);

	// result beat packing, upper bits zero
	assign m_tdata = {3'b000, out_count, out_size, out_id};

endmodule

FILE: src/sodq_checker.sv
// port level checks for the size ordered dedup queue
// depends on sodq_pkg, bound to size_ordered_dedup_queue_core
module sodq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import sodq_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[63:0] == 64'd0)
		else $error("id or size nonzero on a failed command");

	a_busy_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while the queue was idle");

endmodule

bind size_ordered_dedup_queue_core sodq_checker u_chk (.*);

FILE: dv/tb_size_ordered_dedup_queue_core.sv
// self-checking testbench for size_ordered_dedup_queue_core: directed and random
// queue commands checked against a behavioral copy of the sorted queue
// depends on sodq_pkg and size_ordered_dedup_queue_core
module tb_size_ordered_dedup_queue_core;
	import sodq_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out_id;
		logic [31:0] out_size;
		logic [4:0]  count;
	} reply_t;

	// behavioral queue and the replies it predicts
	class queue_scoreboard;
		logic [31:0] ids[$];
		logic [31:0] sizes[$];
		bit          sending[$];
		reply_t      pending[$];
		int          errors;
		int          checked;

		function int find_entry(logic [31:0] id, logic [31:0] sz);
			for (int i = 0; i < ids.size(); i++)
				if (ids[i] == id && sizes[i] == sz) return i;
			return -1;
		endfunction

		function void note_command(logic [1:0] mode, logic [31:0] id, logic [31:0] sz);
			reply_t r;
			int p;
			r = '0;
			case (mode)
				MODE_INSERT: begin
					if (find_entry(id, sz) >= 0) r.status = ST_DUP;
					else if (ids.size() >= QueueDepth) r.status = ST_FULL;
					else begin
						// equal to head lands right after the head
						if (ids.size() == 0 || sizes[0] > sz) p = 0;
						else begin
							p = 1;
							while (p < ids.size() && sizes[p] < sz) p++;
						end
						ids.insert(p, id);
						sizes.insert(p, sz);
						sending.insert(p, 1'b0);
					end
				end
				MODE_PICK: begin
					r.status = ST_NONE;
					for (int i = 0; i < ids.size(); i++)
						if (!sending[i]) begin
							sending[i] = 1'b1;
							r.out_id = ids[i];
							r.out_size = sizes[i];
							r.status = ST_OK;
							break;
						end
				end
				MODE_REMOVE: begin
					p = find_entry(id, sz);
					if (p < 0) r.status = ST_NONE;
					else begin
						ids.delete(p);
						sizes.delete(p);
						sending.delete(p);
					end
				end
				default: begin
					for (int i = ids.size() - 1; i >= 0; i--)
						if (!sending[i]) begin
							ids.delete(i);
							sizes.delete(i);
							sending.delete(i);
						end
				end
			endcase
			r.count = 5'(ids.size());
			pending.push_back(r);
		endfunction

		function void check_reply(reply_t got);
			reply_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("reply beat with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, got.status); errors++;
			end
			if (got.out_id !== e.out_id) begin
				$error("out_id exp %h got %h", e.out_id, got.out_id); errors++;
			end
			if (got.out_size !== e.out_size) begin
				$error("out_size exp %h got %h", e.out_size, got.out_size); errors++;
			end
			if (got.count !== e.count) begin
				$error("count exp %0d got %0d", e.count, got.count); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // file_id[31:0], file_size[63:32]
	logic [1:0]  s_tuser;   // mode[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // out_id[31:0], out_size[63:32], count[68:64]
	logic [1:0]  m_tuser;   // status[1:0]

	queue_scoreboard sb;
	int send_idle;     // idle chance per hundred, sender
	int recv_idle;     // idle chance per hundred, receiver
	int hold_off;      // cycles the receiver stays stalled
	int sent;
	logic [31:0] recent_id[8];
	logic [31:0] recent_size[8];

	size_ordered_dedup_queue_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_reply({m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[68:64]});
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// one command beat, with random idle cycles in front
	// valid stays up after the accept until the next command or idle cycle replaces it
	task automatic send_cmd(input logic [1:0] mode, input logic [31:0] id,
			input logic [31:0] sz);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {sz, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_command(mode, id, sz);
		recent_id[sent[2:0]] = id;
		recent_size[sent[2:0]] = sz;
		sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// random command, biased to small sizes and reused keys so hits happen
	task automatic send_random();
		logic [1:0] mode;
		logic [31:0] id, sz;
		int k;
		k = $urandom_range(99);
		mode = (k < 45) ? MODE_INSERT : (k < 70) ? MODE_PICK : (k < 93) ? MODE_REMOVE
			: MODE_FLUSH;
		if (sent > 0 && $urandom_range(99) < 40) begin
			k = $urandom_range((sent < 8 ? sent : 8) - 1);
			id = recent_id[k[2:0]];
			sz = recent_size[k[2:0]];
		end else begin
			id = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
			sz = ($urandom_range(3) == 0) ? $urandom : $urandom_range(12);
		end
		send_cmd(mode, id, sz);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_INSERT;
		m_tready = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		hold_off = 0;
		sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases, field extremes, head tie, duplicate, full, flush
		send_cmd(MODE_PICK, 32'h0, 32'h0);
		send_cmd(MODE_REMOVE, 32'h1, 32'h1);
		send_cmd(MODE_FLUSH, 32'h0, 32'h0);
		send_cmd(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(MODE_INSERT, 32'h0, 32'h0);
		send_cmd(MODE_INSERT, 32'h5, 32'h0);           // equal to head
		send_cmd(MODE_INSERT, 32'h0, 32'h0);           // duplicate
		send_cmd(MODE_INSERT, 32'hA5A5_5A5A, 32'h8000_0000);
		send_cmd(MODE_PICK, 32'h0, 32'h0);
		send_cmd(MODE_PICK, 32'h0, 32'h0);
		send_cmd(MODE_REMOVE, 32'h0, 32'h0);           // remove a sending entry
		send_cmd(MODE_REMOVE, 32'h5, 32'h1);           // absent
		for (int i = 0; i < 14; i++)
			send_cmd(MODE_INSERT, 32'h100 + i, 32'd20 - i);
		send_cmd(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // duplicate while full
		send_cmd(MODE_INSERT, 32'h999, 32'h3);               // full
		send_cmd(MODE_PICK, 32'h0, 32'h0);
		send_cmd(MODE_FLUSH, 32'h0, 32'h0);

		// pressure: receiver stalls long while commands keep coming
		hold_off = 200;
		for (int i = 0; i < 20; i++) send_random();
		wait_drained();   // sender pauses until every reply is back

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 6 : (ph == 1) ? 64 : 0;
			recv_idle = (ph == 0) ? 64 : (ph == 1) ? 6 : 0;
			for (int i = 0; i < 460; i++) send_random();
		end
		wait_drained();
		repeat (40) @(posedge clk);

		$display("ran %0d commands, %0d replies checked, with stalls, full queue and flushes",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("size_ordered_dedup_queue_core regression: pass");
		else
			$display("size_ordered_dedup_queue_core regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("size_ordered_dedup_queue_core regression: fail");
		$finish;
	end
endmodule

FILE: size_ordered_dedup_queue_core.f
src/sodq_pkg.sv
src/sodq_ctrl.sv
src/sodq_datapath.sv
src/size_ordered_dedup_queue_core.sv
src/sodq_checker.sv
dv/tb_size_ordered_dedup_queue_core.sv
